[hdl/iirdf2_pkg.sv]
// Shared types, widths and helper functions for the direct form II IIR filter.
// Used by the coefficient bank, the multiply-accumulate unit and the top level.
// Depends on nothing.
package iirdf2_pkg;

  localparam int COEF_W           = 18;
  localparam int SAMPLE_W         = 16;
  localparam int LINE_W           = 24;
  localparam int ACC_W            = 48;
  localparam int FRAC_W           = 14;
  localparam int PROD_W           = COEF_W + LINE_W;
  localparam int RND_W            = ACC_W - FRAC_W;
  localparam int CFG_IDX_W        = 3;
  localparam int NUM_FF           = 4;
  localparam int NUM_FB           = 3;
  localparam int FILTER_ORDER_DEF = 3;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [LINE_W-1:0]   line_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [RND_W-1:0]    rnd_t;

  localparam coef_t FF0_RESET = COEF_W'(1) << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0,
    REG_FF1,
    REG_FF2,
    REG_FF3,
    REG_FB1,
    REG_FB2,
    REG_FB3
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sub;
  } mac_ctl_t;

  typedef struct packed {
    logic  clip;
    line_t value;
  } line_sat_t;

  typedef struct packed {
    logic    clip;
    sample_t value;
  } sample_sat_t;

  localparam acc_t RND_HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam rnd_t W_HI     = (RND_W'(1) << (LINE_W - 1)) - RND_W'(1);
  localparam rnd_t W_LO     = ~W_HI;
  localparam rnd_t Y_HI     = (RND_W'(1) << (SAMPLE_W - 1)) - RND_W'(1);
  localparam rnd_t Y_LO     = ~Y_HI;

  // Round half up, then drop the fraction bits.
  function automatic rnd_t round_q14(acc_t a);
    acc_t t;
    t = a + RND_HALF;
    return t[ACC_W-1:FRAC_W];
  endfunction

  function automatic line_sat_t sat_line(rnd_t v);
    line_sat_t r;
    r.clip  = 1'b0;
    r.value = v[LINE_W-1:0];
    if (v > W_HI) begin
      r.clip  = 1'b1;
      r.value = W_HI[LINE_W-1:0];
    end else if (v < W_LO) begin
      r.clip  = 1'b1;
      r.value = W_LO[LINE_W-1:0];
    end
    return r;
  endfunction

  function automatic sample_sat_t sat_sample(rnd_t v);
    sample_sat_t r;
    r.clip  = 1'b0;
    r.value = v[SAMPLE_W-1:0];
    if (v > Y_HI) begin
      r.clip  = 1'b1;
      r.value = Y_HI[SAMPLE_W-1:0];
    end else if (v < Y_LO) begin
      r.clip  = 1'b1;
      r.value = Y_LO[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/iirdf2_coef_regs.sv]
// Coefficient register bank of the IIR filter, written over the configuration channel.
// Depends on iirdf2_pkg.
module iirdf2_coef_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [iirdf2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iirdf2_pkg::COEF_W-1:0]     cfg_data,
  output iirdf2_pkg::coef_t                 ff_coef [iirdf2_pkg::NUM_FF],
  output iirdf2_pkg::coef_t                 fb_coef [iirdf2_pkg::NUM_FB]
);
  import iirdf2_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_coef[0] <= FF0_RESET;
      for (int i = 1; i < NUM_FF; i++) ff_coef[i] <= '0;
      for (int i = 0; i < NUM_FB; i++) fb_coef[i] <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_FF0: ff_coef[0] <= coef_t'(cfg_data);
        REG_FF1: ff_coef[1] <= coef_t'(cfg_data);
        REG_FF2: ff_coef[2] <= coef_t'(cfg_data);
        REG_FF3: ff_coef[3] <= coef_t'(cfg_data);
        REG_FB1: fb_coef[0] <= coef_t'(cfg_data);
        REG_FB2: fb_coef[1] <= coef_t'(cfg_data);
        REG_FB3: fb_coef[2] <= coef_t'(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

[hdl/iirdf2_mac.sv]
// Shared multiply-accumulate unit: one coefficient times one line value per cycle.
// Depends on iirdf2_pkg.
module iirdf2_mac (
  input  logic                 clk,
  input  iirdf2_pkg::mac_ctl_t ctl,
  input  iirdf2_pkg::acc_t     load_val,
  input  iirdf2_pkg::coef_t    coef,
  input  iirdf2_pkg::line_t    data,
  output iirdf2_pkg::acc_t     acc
);
  import iirdf2_pkg::*;

  logic signed [PROD_W-1:0] prod;
  acc_t                     prod_ext;
  acc_t                     base;
  acc_t                     addend;

  always_comb begin
    prod     = coef * data;
    prod_ext = ACC_W'(prod);
    base     = ctl.load ? load_val : acc;
    addend   = '0;
    if (ctl.step) addend = ctl.sub ? -prod_ext : prod_ext;
  end

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.step) acc <= base + addend;
  end

endmodule

[hdl/iir_direct_form_two_filter.sv]
// Top level of the direct form II IIR filter: sequencer, delay line and output register.
// Depends on iirdf2_pkg, iirdf2_coef_regs and iirdf2_mac.
//
//   channel   direction  handshake             word
//   s_*       in         s_tvalid / s_tready   sample_in (tdata), last_sample (tlast)
//   m_*       out        m_tvalid / m_tready   sample_out (tdata), clipped (tuser)
//   cfg_*     in         cfg_valid / cfg_ready register index and 18-bit coefficient
//
// Each sample runs through the single multiply-accumulate unit, one tap per cycle, with
// a rounding step after each sum. Reset is synchronous and clears the sequencer and the
// delay line; it sets the first feedforward coefficient to one and clears the others.
// The next sample is taken while a result still waits in the output register; a stalled
// output holds the sequencer in its last step until the register frees up.
module iir_direct_form_two_filter #(
  parameter int FILTER_ORDER = iirdf2_pkg::FILTER_ORDER_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [iirdf2_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in
  input  logic                             s_tlast,   // last_sample
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [iirdf2_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out
  output logic                             m_tuser,   // [0] clipped
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iirdf2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iirdf2_pkg::COEF_W-1:0]    cfg_data
);
  import iirdf2_pkg::*;

  // An order outside one to three is clamped to that range.
  localparam int ORDER_USED = (FILTER_ORDER < 1) ? 1 :
                              ((FILTER_ORDER > NUM_FB) ? NUM_FB : FILTER_ORDER);
  localparam int TAP_W = $clog2(ORDER_USED + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_WRND,
    ST_FF,
    ST_YRND
  } state_t;

  state_t           state;
  logic [TAP_W-1:0] tap;
  logic             last_flag;
  line_t            w_reg;
  logic             clip_reg;
  line_t            line [ORDER_USED];
  logic             out_valid;
  sample_t          out_sample;
  logic             out_clip;

  coef_t       ff_coef [NUM_FF];
  coef_t       fb_coef [NUM_FB];
  mac_ctl_t    mac_ctl;
  acc_t        load_val;
  coef_t       mac_coef;
  line_t       mac_data;
  acc_t        acc;
  line_sat_t   w_sat;
  sample_sat_t y_sat;
  logic        accept;
  logic        out_free;

  iirdf2_coef_regs u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ff_coef   (ff_coef),
    .fb_coef   (fb_coef)
  );

  iirdf2_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .load_val (load_val),
    .coef     (mac_coef),
    .data     (mac_data),
    .acc      (acc)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_sample;
  assign m_tuser  = out_clip;

  always_comb begin
    mac_ctl  = '0;
    load_val = '0;
    mac_coef = '0;
    mac_data = '0;
    w_sat    = sat_line(round_q14(acc));
    y_sat    = sat_sample(round_q14(acc));
    case (state)
      ST_IDLE: begin
        mac_ctl.load = accept;
        load_val     = ACC_W'(sample_t'(s_tdata)) <<< FRAC_W;
      end
      ST_FB: begin
        mac_ctl.step = 1'b1;
        mac_ctl.sub  = 1'b1;
        for (int i = 0; i < ORDER_USED; i++) begin
          if (tap == TAP_W'(i)) begin
            mac_coef = fb_coef[i];
            mac_data = line[i];
          end
        end
      end
      ST_FF: begin
        mac_ctl.step = 1'b1;
        mac_ctl.load = (tap == '0);
        mac_data     = w_reg;
        for (int i = 0; i <= ORDER_USED; i++) begin
          if (tap == TAP_W'(i)) mac_coef = ff_coef[i];
        end
        for (int i = 0; i < ORDER_USED; i++) begin
          if (tap == TAP_W'(i + 1)) mac_data = line[i];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= '0;
      last_flag <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < ORDER_USED; i++) line[i] <= '0;
    end else begin
      // In the last step the register is refilled below when it is free.
      if (m_tready && state != ST_YRND) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_flag <= s_tlast;
            tap       <= '0;
            state     <= ST_FB;
          end
        end
        ST_FB: begin
          if (tap == TAP_W'(ORDER_USED - 1)) begin
            state <= ST_WRND;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        ST_WRND: begin
          w_reg    <= w_sat.value;
          clip_reg <= w_sat.clip;
          tap      <= '0;
          state    <= ST_FF;
        end
        ST_FF: begin
          if (tap == TAP_W'(ORDER_USED)) begin
            state <= ST_YRND;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        ST_YRND: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_sample <= y_sat.value;
            out_clip   <= clip_reg || y_sat.clip;
            if (last_flag) begin
              for (int i = 0; i < ORDER_USED; i++) line[i] <= '0;
            end else begin
              for (int i = ORDER_USED - 1; i > 0; i--) line[i] <= line[i-1];
              line[0] <= w_reg;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/iirdf2_checker.sv]
// Port-level checks for the IIR filter, bound to the top level.
// Depends on iir_direct_form_two_filter.
module iirdf2_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready
);

  // A result word waits until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word present after reset");

  // The block is busy in the cycle after it takes a sample.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sample taken while previous one is in progress");

  // No result can appear in the cycle after a sample is taken.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result word appeared too early");

endmodule

bind iir_direct_form_two_filter iirdf2_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

[tb/sv/iir_direct_form_two_filter_tb.sv]
// Self-checking testbench for iir_direct_form_two_filter: directed and random sample words
// run through a fixed-point direct form II predictor kept here, under several tap settings.
// Depends on iirdf2_pkg and the filter RTL.
module iir_direct_form_two_filter_tb;
  import iirdf2_pkg::*;

  localparam int ORDER       = FILTER_ORDER_DEF;
  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam coef_t  COEF_MAX = 18'sh1FFFF;
  localparam coef_t  COEF_MIN = 18'sh20000;
  localparam longint LINE_MAX = 64'sd8388607;
  localparam longint LINE_MIN = -64'sd8388608;
  localparam longint OUT_MAX  = 64'sd32767;
  localparam longint OUT_MIN  = -64'sd32768;

  typedef struct {
    sample_t value;
    logic    last;
  } sample_word_t;

  typedef struct {
    sample_t value;
    logic    clip;
  } filter_word_t;

  typedef enum {
    TAPS_RANDOM,
    TAPS_STABLE,
    TAPS_FIR,
    TAPS_EXTREME,
    TAPS_ALL_MAX,
    TAPS_ALL_MIN
  } tap_mix_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  sample_t              s_tdata   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]  m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coef_t                cfg_data  = '0;

  coef_t ff_tap [0:3] = '{FF0_RESET, '0, '0, '0};
  coef_t fb_tap [1:3] = '{default: '0};
  line_t delay_q [0:2] = '{default: '0};

  sample_word_t sample_fifo[$];
  filter_word_t outputs_due[$];

  int errors         = 0;
  int samples_queued = 0;
  int outputs_seen   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  bit s_took         = 1'b0;

  iir_direct_form_two_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_half_up(longint v);
    return (v + 64'sd8192) >>> FRAC_W;
  endfunction

  function automatic filter_word_t iir_step(sample_t x, logic last);
    longint       acc;
    longint       w;
    longint       y;
    int           m;
    filter_word_t r;
    r.clip = 1'b0;
    acc = longint'(x) * 64'sd16384;
    for (m = 1; m <= ORDER; m++) acc -= longint'(fb_tap[m]) * longint'(delay_q[m-1]);
    w = round_half_up(acc);
    if (w > LINE_MAX) begin
      w = LINE_MAX;
      r.clip = 1'b1;
    end else if (w < LINE_MIN) begin
      w = LINE_MIN;
      r.clip = 1'b1;
    end
    acc = longint'(ff_tap[0]) * w;
    for (m = 1; m <= ORDER; m++) acc += longint'(ff_tap[m]) * longint'(delay_q[m-1]);
    y = round_half_up(acc);
    if (y > OUT_MAX) begin
      y = OUT_MAX;
      r.clip = 1'b1;
    end else if (y < OUT_MIN) begin
      y = OUT_MIN;
      r.clip = 1'b1;
    end
    delay_q[2] = delay_q[1];
    delay_q[1] = delay_q[0];
    delay_q[0] = line_t'(w);
    if (last) delay_q = '{default: '0};
    r.value = sample_t'(y);
    return r;
  endfunction

  function automatic coef_t pick_coef(tap_mix_t mix, logic feedback);
    case (mix)
      TAPS_RANDOM:  return coef_t'($urandom);
      TAPS_STABLE:  return feedback ? coef_t'(int'($urandom_range(8191)) - 4096)
                                    : coef_t'(int'($urandom_range(32767)) - 16384);
      TAPS_FIR:     return feedback ? coef_t'(0) : coef_t'($urandom);
      TAPS_ALL_MAX: return COEF_MAX;
      TAPS_ALL_MIN: return COEF_MIN;
      default:      return $urandom_range(1) ? COEF_MAX : COEF_MIN;
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return sample_t'(int'($urandom_range(127)) - 64);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FF0, REG_FF1, REG_FF2, REG_FF3: ff_tap[idx] = value;
      REG_FB1, REG_FB2, REG_FB3:          fb_tap[idx - REG_FB1 + 1] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_taps(input tap_mix_t mix);
    reg_idx_t r;
    r = r.first();
    repeat (r.num()) begin
      write_coef(r, pick_coef(mix, r >= REG_FB1));
      r = r.next();
    end
    if (mix >= TAPS_EXTREME) write_coef(REG_UNUSED, coef_t'($urandom));
  endtask

  task automatic queue_sample(input sample_t value, input logic last);
    sample_word_t word;
    word.value = value;
    word.last  = last;
    sample_fifo.push_back(word);
    samples_queued++;
  endtask

  task automatic queue_block(input int n);
    for (int i = 0; i < n; i++) queue_sample(pick_sample(), i == n - 1 || $urandom_range(19) == 0);
  endtask

  task automatic wait_drained();
    while (outputs_seen < samples_queued) @(posedge clk);
  endtask

  always @(negedge clk) begin
    sample_word_t word;
    if (!s_tvalid || s_took) begin
      if (sample_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        word = sample_fifo.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= word.value;
        s_tlast  <= word.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    filter_word_t due;
    s_took = s_tvalid && s_tready && !rst;
    if (s_took) outputs_due.push_back(iir_step(s_tdata, s_tlast));
    if (!rst && m_tvalid && m_tready) begin
      outputs_seen++;
      if (outputs_due.size() == 0) begin
        $display("%0t: output word with none expected: sample_out %0d clipped %0b",
                 $time, sample_t'(m_tdata), m_tuser);
        errors++;
      end else begin
        due = outputs_due.pop_front();
        if (sample_t'(m_tdata) !== due.value) begin
          $display("%0t: sample_out expected %0d actual %0d",
                   $time, due.value, sample_t'(m_tdata));
          errors++;
        end
        if (m_tuser !== due.clip) begin
          $display("%0t: clipped expected %0b actual %0b", $time, due.clip, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("[iir_direct_form_two_filter] ERROR");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 17;
    recv_idle_pct = 63;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unity pass-through with the reset taps, then saturating taps at both extremes.
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh0000, 1'b0);
    queue_sample(16'sh0001, 1'b0);
    queue_sample(16'shFFFF, 1'b0);
    queue_sample(16'sh5555, 1'b0);
    queue_sample(16'shAAAA, 1'b1);
    wait_drained();
    load_taps(TAPS_ALL_MAX);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh0064, 1'b0);
    queue_sample(16'shFF9C, 1'b1);
    queue_sample(16'sh0001, 1'b0);
    wait_drained();
    load_taps(TAPS_ALL_MIN);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'shFFFF, 1'b0);
    queue_sample(16'sh0000, 1'b1);
    queue_sample(16'sh0001, 1'b0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 17;
        recv_idle_pct = 63;
      end else if (ph < 8) begin
        send_idle_pct = 63;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_taps(tap_mix_t'(ph % 4));
      queue_block($urandom_range(1, 30));
      if (ph == 5) wait_drained();
      queue_block($urandom_range(1, 30));
      queue_block($urandom_range(1, 30));
      if (ph == 1 || ph == 9) hold_requests++;
      wait_drained();
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (outputs_due.size() != 0) begin
      $display("%0t: %0d expected output words never arrived", $time, outputs_due.size());
      errors++;
    end
    if (errors == 0) $display("[iir_direct_form_two_filter] OK");
    else $display("[iir_direct_form_two_filter] ERROR");
    $finish;
  end

endmodule
